[rtl/lbpc_pkg.sv]
`timescale 1ns / 1ps

package lbpc_pkg;

  localparam int OP_W       = 3;
  localparam int SIZE_W     = 21;
  localparam int BLEN_W     = 17;
  localparam int POS_W      = 21;
  localparam int CUR_W      = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam int DIV_STEPS  = 21;
  localparam int DIV_CNT_W  = 5;

  localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST  = 21'd1048576;
  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST = 17'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT       = 3'd0,
    OP_FETCH      = 3'd1,
    OP_ADVANCE    = 3'd2,
    OP_SET_LOOP   = 3'd3,
    OP_SET_REGION = 3'd4,
    OP_REWIND     = 3'd5,
    OP_SET_PAUSE  = 3'd6,
    OP_SET_CURSOR = 3'd7
  } op_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic commit;
  } lbpc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } lbpc_status_t;

endpackage

[rtl/lbpc_in_if.sv]
`timescale 1ns / 1ps

interface lbpc_in_if import lbpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic              flag;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_end;

  modport source (output valid, op, flag, position, position_end, input ready);
  modport sink   (input valid, op, flag, position, position_end, output ready);
endinterface

[rtl/lbpc_out_if.sv]
`timescale 1ns / 1ps

interface lbpc_out_if import lbpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             block_valid;
  logic [POS_W-1:0] block_address;
  logic [POS_W-1:0] region_start_now;
  logic [POS_W-1:0] region_end_now;
  logic             loop_now;
  logic             paused_now;
  logic             error;

  modport source (output valid, block_valid, block_address, region_start_now,
                  region_end_now, loop_now, paused_now, error, input ready);
  modport sink   (input valid, block_valid, block_address, region_start_now,
                  region_end_now, loop_now, paused_now, error, output ready);
endinterface

[rtl/lbpc_ctrl.sv]
`timescale 1ns / 1ps

module lbpc_ctrl import lbpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lbpc_status_t status,
  output lbpc_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

[rtl/lbpc_datapath.sv]
`timescale 1ns / 1ps

module lbpc_datapath import lbpc_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lbpc_cmd_t             cmd,
  output lbpc_status_t          status,
  input  logic [OP_W-1:0]       in_op,
  input  logic                  in_flag,
  input  logic [POS_W-1:0]      in_position,
  input  logic [POS_W-1:0]      in_position_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_block_valid,
  output logic [POS_W-1:0]      out_block_address,
  output logic [POS_W-1:0]      out_region_start_now,
  output logic [POS_W-1:0]      out_region_end_now,
  output logic                  out_loop_now,
  output logic                  out_paused_now,
  output logic                  out_error,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [32:0] SIZE_LIMIT = 33'd1 << ADDR_BITS;

  // latched item
  op_t              op_r;
  logic             flag_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_end_r;

  // configuration
  logic [SIZE_W-1:0] buffer_size_r;
  logic [BLEN_W-1:0] block_length_r;

  // playback state
  logic              init_r, init_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [POS_W-1:0]  capacity_r, capacity_nxt;
  logic [POS_W-1:0]  rs_r, rs_nxt;
  logic [POS_W-1:0]  re_r, re_nxt;
  logic [POS_W-1:0]  ps_r, ps_nxt;
  logic [POS_W-1:0]  pe_r, pe_nxt;
  logic              la_r, la_nxt;
  logic              lp_r, lp_nxt;
  logic              lcr_r, lcr_nxt;
  logic              rcr_r, rcr_nxt;
  logic              rew_r, rew_nxt;
  logic              preq_r, preq_nxt;
  logic              plat_r, plat_nxt;
  logic              fseen_r, fseen_nxt;

  // remainder unit
  logic [BLEN_W-1:0]    rem_r;
  logic [POS_W-1:0]     dvd_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [BLEN_W:0]      rem_sh;
  logic [POS_W-1:0]     dividend;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             ov_block_valid_r;
  logic [POS_W-1:0] ov_addr_r;
  logic             ov_error_r;
  logic             res_valid;
  logic             res_error;

  logic [SIZE_W-1:0] size_sat;
  logic              blen_zero;
  logic              region_ok;
  logic [POS_W-1:0]  div_res;

  // update rule
  logic             rew_in;
  logic             la_u;
  logic [POS_W-1:0] rs_u, re_u;
  logic [CUR_W-1:0] cur_u;
  logic             rew_u;
  logic             moved_u;
  logic             relocate;
  logic [CUR_W-1:0] cur_adv;
  logic [CUR_W-1:0] cur_step;

  assign size_sat  = ({12'd0, buffer_size_r} > SIZE_LIMIT) ?
                     SIZE_LIMIT[SIZE_W-1:0] : buffer_size_r;
  assign blen_zero = (block_length_r == '0);
  assign region_ok = !blen_zero && (pos_r < capacity_r) && (pos_end_r <= capacity_r)
                     && (pos_r <= pos_end_r);

  assign status.need_div = ((op_r == OP_INIT) && !blen_zero) ||
                           ((op_r == OP_SET_REGION) && init_r && region_ok);
  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.out_free = !out_valid_r || out_ready;

  assign dividend = (op_r == OP_INIT) ? size_sat : (pos_end_r - pos_r);
  assign rem_sh   = {rem_r, dvd_r[POS_W-1]};
  // floor(n / len) * len is n minus the remainder
  assign div_res  = ((op_r == OP_INIT) ? size_sat : pos_end_r) - {4'd0, rem_r};

  always_comb begin
    rew_in   = rew_r || (op_r == OP_REWIND);
    la_u     = lcr_r ? lp_r : la_r;
    rs_u     = rcr_r ? ps_r : rs_r;
    re_u     = rcr_r ? pe_r : re_r;
    relocate = rcr_r && ((cursor_r < {1'b0, ps_r}) || (cursor_r > {1'b0, pe_r})) &&
               (la_u || (cursor_r < {1'b0, ps_r}));
    cur_u    = cursor_r;
    rew_u    = rew_in;
    moved_u  = 1'b0;
    priority if (relocate) begin
      cur_u   = {1'b0, rs_u};
      rew_u   = 1'b0;
      moved_u = 1'b1;
    end else if (rew_in) begin
      cur_u   = {1'b0, rs_u};
      rew_u   = 1'b0;
      moved_u = 1'b1;
    end else if (la_u && (cursor_r >= {1'b0, re_u})) begin
      cur_u   = {1'b0, rs_u};
      moved_u = 1'b1;
    end
  end

  assign cur_adv  = (cursor_r < {1'b0, re_u}) ? cursor_r + CUR_W'(block_length_r) : cursor_r;
  assign cur_step = (la_u && (cur_adv >= {1'b0, re_u})) ? {1'b0, rs_u} : cur_adv;

  always_comb begin
    init_nxt     = init_r;
    cursor_nxt   = cursor_r;
    capacity_nxt = capacity_r;
    rs_nxt       = rs_r;
    re_nxt       = re_r;
    ps_nxt       = ps_r;
    pe_nxt       = pe_r;
    la_nxt       = la_r;
    lp_nxt       = lp_r;
    lcr_nxt      = lcr_r;
    rcr_nxt      = rcr_r;
    rew_nxt      = rew_r;
    preq_nxt     = preq_r;
    plat_nxt     = plat_r;
    fseen_nxt    = fseen_r;
    res_valid    = 1'b0;
    res_error    = 1'b0;
    if (cmd.commit) begin
      unique case (op_r)
        OP_INIT: begin
          if (blen_zero) begin
            res_error = 1'b1;
          end else begin
            capacity_nxt = div_res;
            la_nxt       = flag_r;
            lp_nxt       = flag_r;
            rs_nxt       = '0;
            ps_nxt       = '0;
            re_nxt       = div_res;
            pe_nxt       = div_res;
            init_nxt     = 1'b1;
          end
        end
        OP_FETCH: begin
          if (init_r) begin
            if (!fseen_r) begin
              la_nxt     = la_u;
              lcr_nxt    = 1'b0;
              rs_nxt     = rs_u;
              re_nxt     = re_u;
              rcr_nxt    = 1'b0;
              cursor_nxt = cur_u;
              rew_nxt    = rew_u;
              plat_nxt   = preq_r;
              fseen_nxt  = 1'b1;
              res_valid  = (cur_u < {1'b0, re_u}) && !preq_r;
            end else begin
              res_valid  = (cursor_r < {1'b0, re_r}) && !plat_r;
            end
          end
        end
        OP_ADVANCE: begin
          if (init_r) begin
            la_nxt  = la_u;
            lcr_nxt = 1'b0;
            rs_nxt  = rs_u;
            re_nxt  = re_u;
            rcr_nxt = 1'b0;
            rew_nxt = rew_u;
            if (moved_u) begin
              cursor_nxt = cur_u;
            end else begin
              if (!plat_r) begin
                cursor_nxt = cur_step;
              end
              fseen_nxt = 1'b0;
            end
          end
        end
        OP_SET_LOOP: begin
          if (init_r) begin
            lp_nxt  = flag_r;
            lcr_nxt = 1'b1;
          end
        end
        OP_SET_REGION: begin
          if (init_r) begin
            if (!region_ok) begin
              res_error = 1'b1;
            end else begin
              ps_nxt  = pos_r;
              pe_nxt  = div_res;
              rcr_nxt = 1'b1;
            end
          end
        end
        OP_REWIND: begin
          if (init_r) begin
            la_nxt     = la_u;
            lcr_nxt    = 1'b0;
            rs_nxt     = rs_u;
            re_nxt     = re_u;
            rcr_nxt    = 1'b0;
            cursor_nxt = cur_u;
            rew_nxt    = rew_u;
          end
        end
        OP_SET_PAUSE: begin
          preq_nxt = flag_r;
        end
        OP_SET_CURSOR: begin
          if (pos_r <= capacity_r) begin
            cursor_nxt = {1'b0, pos_r};
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r  <= BUFFER_SIZE_RST;
      block_length_r <= BLOCK_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_SIZE:  buffer_size_r  <= cfg_data[SIZE_W-1:0];
        CFG_BLOCK_LENGTH: block_length_r <= cfg_data[BLEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b0;
      cursor_r    <= '0;
      capacity_r  <= '0;
      rs_r        <= '0;
      re_r        <= '0;
      ps_r        <= '0;
      pe_r        <= '0;
      la_r        <= 1'b0;
      lp_r        <= 1'b0;
      lcr_r       <= 1'b0;
      rcr_r       <= 1'b0;
      rew_r       <= 1'b0;
      preq_r      <= 1'b0;
      plat_r      <= 1'b0;
      fseen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      init_r      <= init_nxt;
      cursor_r    <= cursor_nxt;
      capacity_r  <= capacity_nxt;
      rs_r        <= rs_nxt;
      re_r        <= re_nxt;
      ps_r        <= ps_nxt;
      pe_r        <= pe_nxt;
      la_r        <= la_nxt;
      lp_r        <= lp_nxt;
      lcr_r       <= lcr_nxt;
      rcr_r       <= rcr_nxt;
      rew_r       <= rew_nxt;
      preq_r      <= preq_nxt;
      plat_r      <= plat_nxt;
      fseen_r     <= fseen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_op);
      flag_r    <= in_flag;
      pos_r     <= in_position;
      pos_end_r <= in_position_end;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, block_length_r}) begin
        rem_r <= BLEN_W'(rem_sh - {1'b0, block_length_r});
      end else begin
        rem_r <= rem_sh[BLEN_W-1:0];
      end
      dvd_r <= {dvd_r[POS_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.commit) begin
      ov_block_valid_r <= res_valid;
      ov_addr_r        <= cursor_nxt[POS_W-1:0];
      ov_error_r       <= res_error;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_block_valid      = ov_block_valid_r;
  assign out_block_address    = ov_addr_r;
  assign out_error            = ov_error_r;
  // pending values and pause request only change at commit
  assign out_region_start_now = ps_r;
  assign out_region_end_now   = pe_r;
  assign out_loop_now         = lp_r;
  assign out_paused_now       = preq_r;

endmodule

[rtl/looped_block_playback_cursor.sv]
// Result: most ops commit from S_EXEC to the output register once that register is free;
//   init and set region may first run the 21-step bit-serial remainder (one bit a cycle).
// One item is in flight at a time; the next is taken only once the result is committed.
// A new item is taken while the previous result waits in the output register.
// Reset: synchronous, active low; clears all playback state, buffer_size to 1048576
//   and block_length to 256.
`timescale 1ns / 1ps

module looped_block_playback_cursor import lbpc_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lbpc_in_if.sink               in_ch,
  lbpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lbpc_cmd_t    cmd;
  lbpc_status_t status;

  lbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lbpc_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_op                (in_ch.op),
    .in_flag              (in_ch.flag),
    .in_position          (in_ch.position),
    .in_position_end      (in_ch.position_end),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_block_valid      (out_ch.block_valid),
    .out_block_address    (out_ch.block_address),
    .out_region_start_now (out_ch.region_start_now),
    .out_region_end_now   (out_ch.region_end_now),
    .out_loop_now         (out_ch.loop_now),
    .out_paused_now       (out_ch.paused_now),
    .out_error            (out_ch.error),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without an item in flight");

  a_valid_excl_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.block_valid && out_ch.error))
    else $error("block_valid and error both set");

endmodule
